@@ hw/rtl/qatb_pkg.sv @@
// shared types and constants of the argument tokenizer and batcher
`timescale 1ns / 1ps

package qatb_pkg;

    // widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int ARG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int SLOTS   = 4;
    localparam int COUNT_W = 3;

    // result kinds
    localparam logic [KIND_W-1:0] K_BYTE     = 3'd0;
    localparam logic [KIND_W-1:0] K_KEPT     = 3'd1;
    localparam logic [KIND_W-1:0] K_LONG     = 3'd2;
    localparam logic [KIND_W-1:0] K_RUN      = 3'd3;
    localparam logic [KIND_W-1:0] K_FINISHED = 3'd4;
    localparam logic [KIND_W-1:0] K_ABORTED  = 3'd5;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ARG_SPACE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_ARGS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ABORT     = 2'd2;

    // characters with a meaning to the tokenizer
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DQ  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQ  = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h5C;

    typedef struct packed {
        logic [ARG_W-1:0] arg_space;
        logic [ARG_W-1:0] max_args;
        logic             abort_on_long;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic [ARG_W-1:0]  arg_length;
    } result_t;

    // all results caused by one input beat, in order
    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        result_t [SLOTS-1:0]       res;
    } group_t;

endpackage

@@ hw/rtl/qatb_tokenizer.sv @@
// tokenizer and batcher state with the per-beat next-state and result logic
`timescale 1ns / 1ps

module qatb_tokenizer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  logic [qatb_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           in_eoi,
    input  qatb_pkg::cfg_t                 cfg,
    output qatb_pkg::group_t               grp
);
    import qatb_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam int CW = (LB > ARG_W) ? LB : ARG_W;
    localparam logic [LB-1:0] LMASK = '1;

    localparam logic [1:0] PH_SKIP  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic             dq_reg, dq_next;
    logic             sq_reg, sq_next;
    logic             esc_reg, esc_next;
    logic [LB-1:0]    tl_reg, tl_next;
    logic [LB:0]      bb_reg, bb_next;
    logic [ARG_W-1:0] ba_reg, ba_next;

    logic [CW-1:0] space_w;
    logic [LB-1:0] lim;
    logic [LB-1:0] lim_m1;
    logic          is_ws;

    // effective budget, clamped to 2 .. 2^LB-1
    always_comb begin
        space_w = CW'(cfg.arg_space);
        if (space_w > CW'(LMASK)) begin
            lim = LMASK;
        end else if (cfg.arg_space < 16'd2) begin
            lim = LB'(2);
        end else begin
            lim = space_w[LB-1:0];
        end
        lim_m1 = lim - 1'b1;
        is_ws  = in_byte inside {CH_SP, [CH_TAB:CH_CR]};
    end

    // per-beat state update and result list
    always_comb begin
        logic [COUNT_W-1:0] n;
        logic               end_tok;
        logic               store_c;
        logic               fin;
        logic [LB-1:0]      len;
        logic [CW-1:0]      len_w;
        logic [LB+1:0]      bb_sum;

        phase_next = phase_reg;
        dq_next    = dq_reg;
        sq_next    = sq_reg;
        esc_next   = esc_reg;
        tl_next    = tl_reg;
        bb_next    = bb_reg;
        ba_next    = ba_reg;
        grp        = '0;
        n          = '0;
        end_tok    = 1'b0;
        store_c    = 1'b0;
        fin        = 1'b0;
        len        = tl_reg;
        len_w      = CW'(tl_reg);
        bb_sum     = (LB+2)'(bb_reg) + (LB+2)'(tl_reg);

        if (phase_reg != PH_DONE) begin
            // classify the byte
            if (in_eoi) begin
                end_tok = (phase_reg == PH_TOKEN);
            end else if (!(phase_reg == PH_SKIP && is_ws)) begin
                phase_next = PH_TOKEN;
                if (esc_reg) begin
                    esc_next = 1'b0;
                    store_c  = 1'b1;
                end else if (in_byte == CH_NL) begin
                    end_tok = 1'b1;
                end else if (!dq_reg && !sq_reg && (in_byte == CH_SP || in_byte == CH_TAB)) begin
                    end_tok = 1'b1;
                end else if (in_byte == CH_DQ && !sq_reg) begin
                    dq_next = !dq_reg;
                end else if (in_byte == CH_SQ && !dq_reg) begin
                    sq_next = !sq_reg;
                end else if (in_byte == CH_BS && !dq_reg && !sq_reg) begin
                    esc_next = 1'b1;
                end else begin
                    store_c = 1'b1;
                end
            end

            // pass the byte on while below the length limit
            if (store_c && tl_reg < lim_m1) begin
                grp.res[n[1:0]].kind     = K_BYTE;
                grp.res[n[1:0]].out_byte = in_byte;
                n       = n + 1'b1;
                tl_next = tl_reg + 1'b1;
            end

            // argument end
            if (end_tok) begin
                dq_next    = 1'b0;
                sq_next    = 1'b0;
                esc_next   = 1'b0;
                tl_next    = '0;
                phase_next = PH_SKIP;
                if (len == '0) begin
                    fin = 1'b1;
                end else if (len >= lim_m1) begin
                    grp.res[n[1:0]].kind       = K_LONG;
                    grp.res[n[1:0]].arg_length = len_w[ARG_W-1:0];
                    n = n + 1'b1;
                    if (cfg.abort_on_long) begin
                        grp.res[n[1:0]].kind = K_ABORTED;
                        n          = n + 1'b1;
                        phase_next = PH_DONE;
                    end
                end else begin
                    if (bb_sum > (LB+2)'(lim) ||
                        (cfg.max_args != '0 && ba_reg == cfg.max_args)) begin
                        grp.res[n[1:0]].kind       = K_RUN;
                        grp.res[n[1:0]].arg_length = ba_reg;
                        n      = n + 1'b1;
                        ba_next = '0;
                        bb_next = '0;
                    end
                    grp.res[n[1:0]].kind       = K_KEPT;
                    grp.res[n[1:0]].arg_length = len_w[ARG_W-1:0];
                    n       = n + 1'b1;
                    ba_next = ba_next + 1'b1;
                    bb_next = bb_next + (LB+1)'(len);
                end
            end

            // stream end: run what is pending, then finish
            if (fin || (in_eoi && phase_next != PH_DONE)) begin
                if (ba_next != '0) begin
                    grp.res[n[1:0]].kind       = K_RUN;
                    grp.res[n[1:0]].arg_length = ba_next;
                    n = n + 1'b1;
                end
                grp.res[n[1:0]].kind = K_FINISHED;
                n          = n + 1'b1;
                ba_next    = '0;
                bb_next    = '0;
                phase_next = PH_DONE;
            end
        end
        grp.count = n;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            dq_reg    <= 1'b0;
            sq_reg    <= 1'b0;
            esc_reg   <= 1'b0;
            tl_reg    <= '0;
            bb_reg    <= '0;
            ba_reg    <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            dq_reg    <= dq_next;
            sq_reg    <= sq_next;
            esc_reg   <= esc_next;
            tl_reg    <= tl_next;
            bb_reg    <= bb_next;
            ba_reg    <= ba_next;
        end
    end

    // the stream stays ended until reset
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("tokenizer left the done phase");

    // an ended stream yields nothing
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == PH_DONE |-> grp.count == '0)
        else $error("result after stream end");

    // only one kind of quoting is open at a time
    a_quote_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dq_reg && sq_reg))
        else $error("both quote kinds open");

endmodule

@@ hw/rtl/qatb_result_buf.sv @@
// result register that sends the results of one beat out one at a time
`timescale 1ns / 1ps

module qatb_result_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  qatb_pkg::group_t              grp,
    output logic                          can_load,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qatb_pkg::KIND_W-1:0]   m_kind,
    output logic [qatb_pkg::BYTE_W-1:0]   m_out_byte,
    output logic [qatb_pkg::ARG_W-1:0]    m_arg_length,
    output logic                          m_last
);
    import qatb_pkg::*;

    result_t [SLOTS-1:0] entries_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [1:0]          head_reg;
    logic                m_fire;

    // output of the head entry
    assign m_valid      = (rem_reg != '0);
    assign m_fire       = m_valid && m_ready;
    assign can_load     = (rem_reg == '0) || (m_ready && rem_reg == COUNT_W'(1));
    assign m_kind       = entries_reg[head_reg].kind;
    assign m_out_byte   = entries_reg[head_reg].out_byte;
    assign m_arg_length = entries_reg[head_reg].arg_length;
    assign m_last       = (rem_reg == COUNT_W'(1));

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            entries_reg <= grp.res;
        end
    end

    // remaining count and head pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            head_reg <= '0;
        end else if (load) begin
            rem_reg  <= grp.count;
            head_reg <= '0;
        end else if (m_fire) begin
            rem_reg  <= rem_reg - 1'b1;
            head_reg <= head_reg + 1'b1;
        end
    end

    // a loaded non-empty group shows up on the output
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load && grp.count != '0 |=> m_valid)
        else $error("loaded results not presented");

    // the pointer never runs past the slots
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, head_reg} + rem_reg) <= COUNT_W'(SLOTS))
        else $error("result pointer out of range");

endmodule

@@ hw/rtl/quoted_argument_tokenizer_batcher_unit.sv @@
// top level of the quoted argument tokenizer and batcher
`timescale 1ns / 1ps

// Splits a byte stream into arguments with quoting and backslash escapes,
// passes each kept byte on as a beat of its own, reports every argument as
// kept or too long and marks where a batch must be run. A beat enters an
// input register; the tokenizer logic updates its state and loads all
// results of that beat into the result register, which sends them one
// beat per cycle while m_ready is high. Bytes that yield at most one
// result each stream at one byte per cycle while m_ready is high; a beat
// that ends an argument or the stream yields up to four results and holds
// the result register until all are sent, while the next beat waits in
// the input register. After the stream has finished or aborted, further
// input beats are taken and give no result until reset.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wr_data.

module quoted_argument_tokenizer_batcher_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [qatb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [qatb_pkg::ARG_W-1:0]    cfg_wr_data,
    // input beats
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [qatb_pkg::BYTE_W-1:0]   s_in_byte,
    input  logic                          s_end_of_input,
    // result beats
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qatb_pkg::KIND_W-1:0]   m_kind,
    output logic [qatb_pkg::BYTE_W-1:0]   m_out_byte,
    output logic [qatb_pkg::ARG_W-1:0]    m_arg_length,
    output logic                          m_last
);
    import qatb_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eoi_reg;
    logic              can_load;
    logic              fire;
    group_t            grp;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.arg_space     <= 16'd2048;
            cfg_reg.max_args      <= '0;
            cfg_reg.abort_on_long <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ARG_SPACE: cfg_reg.arg_space     <= cfg_wr_data;
                REG_MAX_ARGS:  cfg_reg.max_args      <= cfg_wr_data;
                REG_ABORT:     cfg_reg.abort_on_long <= cfg_wr_data[0];
                default:       ;
            endcase
        end
    end

    // input register
    assign fire    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_eoi_reg  <= s_end_of_input;
        end
    end

    qatb_tokenizer #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_tokenizer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .in_eoi  (in_eoi_reg),
        .cfg     (cfg_reg),
        .grp     (grp)
    );

    qatb_result_buf u_result_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (fire),
        .grp          (grp),
        .can_load     (can_load),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_byte   (m_out_byte),
        .m_arg_length (m_arg_length),
        .m_last       (m_last)
    );

endmodule
